// ----- rtl/cbq_pkg.sv -----
`timescale 1ns / 1ps

package cbq_pkg;

  // filter structure
  localparam int SECTIONS    = 2;
  localparam int NUM_COEF_RG = 2;

  // datapath widths
  localparam int SAMPLE_W  = 24;
  localparam int GAIN_W    = 32;
  localparam int COEF_W    = 16;
  localparam int HIST_W    = 32;
  localparam int MUL_W     = HIST_W + COEF_W;
  localparam int ACC_W     = 50;
  localparam int GPROD_W   = SAMPLE_W + GAIN_W;
  localparam int COEF_FRAC = 14;
  localparam int GAIN_FRAC = 24;

  // register port
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 5;

  localparam logic [1:0] REG_GAIN = 2'd0;
  localparam logic [1:0] REG_SEC0 = 2'd1;
  localparam logic [1:0] REG_SEC1 = 2'd2;

  localparam logic signed [GAIN_W-1:0] GAIN_RESET = 32'sd16777216;

  localparam logic signed [ACC_W-1:0]   ACC_HALF   = ACC_W'(1) <<< (COEF_FRAC - 1);
  localparam logic signed [GPROD_W-1:0] GPROD_HALF = GPROD_W'(1) <<< (GAIN_FRAC - 1);

  // per-cell sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_P1,
    ST_P2,
    ST_W,
    ST_Z1,
    ST_Z2,
    ST_DONE
  } cell_state_t;

  // data handed from one stage to the next
  typedef struct packed {
    logic                     valid;
    logic signed [HIST_W-1:0] data;
  } hand_t;

  // round half up by COEF_FRAC bits, then saturate to the history range
  function automatic logic signed [HIST_W-1:0] rnd_sat_acc(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0]           t;
    logic [ACC_W-COEF_FRAC-1:0]        q;
    logic [ACC_W-COEF_FRAC-HIST_W:0]   top;
    t   = v + ACC_HALF;
    q   = t[ACC_W-1:COEF_FRAC];
    top = q[ACC_W-COEF_FRAC-1:HIST_W-1];
    if ((&top) || !(|top)) begin
      rnd_sat_acc = q[HIST_W-1:0];
    end else if (q[ACC_W-COEF_FRAC-1]) begin
      rnd_sat_acc = {1'b1, {(HIST_W-1){1'b0}}};
    end else begin
      rnd_sat_acc = {1'b0, {(HIST_W-1){1'b1}}};
    end
  endfunction

  // round half up by GAIN_FRAC bits; 24 x 32 product always fits afterwards
  function automatic logic signed [HIST_W-1:0] rnd_gain(input logic signed [GPROD_W-1:0] v);
    logic signed [GPROD_W-1:0] t;
    t = v + GPROD_HALF;
    rnd_gain = t[GAIN_FRAC+HIST_W-1:GAIN_FRAC];
  endfunction

  // saturate a history-width word to the sample range
  function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [HIST_W-1:0] v);
    logic [HIST_W-SAMPLE_W:0] top;
    top = v[HIST_W-1:SAMPLE_W-1];
    if ((&top) || !(|top)) begin
      sat_sample = v[SAMPLE_W-1:0];
    end else if (v[HIST_W-1]) begin
      sat_sample = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      sat_sample = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  endfunction

endpackage

// ----- rtl/cascaded_biquad_iir_filter.sv -----
`timescale 1ns / 1ps

// Cascaded biquad IIR filter, direct form II, fixed point.
// Input channel: in_valid / in_stall with in_sample_in (signed 24 bit); a
// transaction completes on a rising edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall with out_sample_out (signed 24 bit,
// saturated); the downstream side raises out_stall to hold the result, which
// then stays unchanged in the output register.
// Registers (APB, 64-bit data, 8-byte stride): 0x00 overall gain Q8.24,
// 0x08 and 0x10 section coefficients, four Q2.14 words each.
// Datapath: a gain stage followed by a chain of SECTIONS biquad cells. Each
// cell owns its two history words and one 32x16 multiply-accumulate unit and
// steps through a sequence for each sample (load, two pole products, history
// update, two zero products, hand-off).
// A sample passes through the gain register, each cell in turn and the output
// register. A cell takes a new sample only after handing off the last one, so
// its MAC sequence sets the rate; the cells work on successive samples in parallel.
// When the receiver stalls, results back up through the output register and
// cells, and in_stall rises once the gain stage is full.
// Reset (rst_n, synchronous, active low) clears the history words, empties
// the pipeline and restores gain 1.0 and zero coefficients.
module cascaded_biquad_iir_filter import cbq_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [SAMPLE_W-1:0]   in_sample_in,
  // output channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [SAMPLE_W-1:0]   out_sample_out,
  // register port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [CFG_ADDR_W-1:0]        paddr,
  input  logic [CFG_DATA_W-1:0]        pwdata,
  output logic [CFG_DATA_W-1:0]        prdata,
  output logic                         pready
);

  logic signed [GAIN_W-1:0] gain_r;
  logic [4*COEF_W-1:0]      coef_r [NUM_COEF_RG];
  logic [1:0]               reg_idx;
  logic                     wr_en;

  hand_t link [SECTIONS+1];
  logic  link_ready [SECTIONS+1];
  logic  gain_ready;

  logic                       out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_W-1:0] out_sample_r, out_sample_nxt;

  // register port
  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_ADDR_W-1:3];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r    <= GAIN_RESET;
      coef_r[0] <= '0;
      coef_r[1] <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_GAIN: gain_r    <= pwdata[GAIN_W-1:0];
        REG_SEC0: coef_r[0] <= pwdata;
        REG_SEC1: coef_r[1] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_GAIN: prdata = {{(CFG_DATA_W-GAIN_W){gain_r[GAIN_W-1]}}, gain_r};
      REG_SEC0: prdata = coef_r[0];
      REG_SEC1: prdata = coef_r[1];
      default:  prdata = '0;
    endcase
  end

  // gain stage
  cbq_gain u_gain (
    .clk         (clk),
    .rst_n       (rst_n),
    .up_valid_i  (in_valid),
    .up_sample_i (in_sample_in),
    .up_ready_o  (gain_ready),
    .gain_i      (gain_r),
    .dn_o        (link[0]),
    .dn_ready_i  (link_ready[0])
  );

  assign in_stall = !gain_ready;

  // chain of biquad cells
  for (genvar s = 0; s < SECTIONS; s++) begin : g_cell
    cbq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .up_i       (link[s]),
      .up_ready_o (link_ready[s]),
      .coefs_i    (coef_r[s]),
      .dn_o       (link[s+1]),
      .dn_ready_i (link_ready[s+1])
    );
  end

  // output register
  assign link_ready[SECTIONS] = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_sample_nxt = out_sample_r;
    if (link[SECTIONS].valid && link_ready[SECTIONS]) begin
      out_valid_nxt  = 1'b1;
      out_sample_nxt = sat_sample(link[SECTIONS].data);
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_sample_r <= out_sample_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;

endmodule

// ----- rtl/cbq_gain.sv -----
`timescale 1ns / 1ps

module cbq_gain import cbq_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       up_valid_i,
  input  logic signed [SAMPLE_W-1:0] up_sample_i,
  output logic                       up_ready_o,
  input  logic signed [GAIN_W-1:0]   gain_i,
  output hand_t                      dn_o,
  input  logic                       dn_ready_i
);

  logic                      valid_r, valid_nxt;
  logic signed [GPROD_W-1:0] prod_r, prod_nxt;

  // one product register, refilled as soon as the first cell takes it
  always_comb begin
    up_ready_o = !valid_r || dn_ready_i;
    valid_nxt  = valid_r;
    prod_nxt   = prod_r;
    if (up_valid_i && up_ready_o) begin
      valid_nxt = 1'b1;
      prod_nxt  = GPROD_W'(up_sample_i) * GPROD_W'(gain_i);
    end else if (dn_ready_i) begin
      valid_nxt = 1'b0;
    end
  end

  assign dn_o.valid = valid_r;
  assign dn_o.data  = rnd_gain(prod_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

// ----- rtl/cbq_cell.sv -----
`timescale 1ns / 1ps

module cbq_cell import cbq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  hand_t                 up_i,
  output logic                  up_ready_o,
  input  logic [4*COEF_W-1:0]   coefs_i,
  output hand_t                 dn_o,
  input  logic                  dn_ready_i
);

  cell_state_t              state_r, state_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [HIST_W-1:0] w_r, w_nxt;
  logic signed [HIST_W-1:0] h1_r, h1_nxt;
  logic signed [HIST_W-1:0] h2_r, h2_nxt;

  logic signed [COEF_W-1:0] pole1, pole2, zero1, zero2;
  logic signed [HIST_W-1:0] mul_h;
  logic signed [COEF_W-1:0] mul_c;
  logic signed [MUL_W-1:0]  mul_p;
  logic signed [ACC_W-1:0]  mul_ext;
  logic signed [HIST_W-1:0] acc_rnd;

  assign pole1 = coefs_i[COEF_W-1:0];
  assign pole2 = coefs_i[2*COEF_W-1:COEF_W];
  assign zero1 = coefs_i[3*COEF_W-1:2*COEF_W];
  assign zero2 = coefs_i[4*COEF_W-1:3*COEF_W];

  // shared multiplier operand select
  always_comb begin
    case (state_r)
      ST_P1:   begin mul_h = h1_r; mul_c = pole1; end
      ST_P2:   begin mul_h = h2_r; mul_c = pole2; end
      ST_Z1:   begin mul_h = h1_r; mul_c = zero1; end
      ST_Z2:   begin mul_h = h2_r; mul_c = zero2; end
      default: begin mul_h = h1_r; mul_c = pole1; end
    endcase
  end

  assign mul_p   = MUL_W'(mul_h) * MUL_W'(mul_c);
  assign mul_ext = ACC_W'(mul_p);
  assign acc_rnd = rnd_sat_acc(acc_r);

  // section sequencer: poles, new history value, zeros, hand off
  always_comb begin
    state_nxt  = state_r;
    acc_nxt    = acc_r;
    w_nxt      = w_r;
    h1_nxt     = h1_r;
    h2_nxt     = h2_r;
    up_ready_o = (state_r == ST_IDLE);
    dn_o.valid = (state_r == ST_DONE);
    dn_o.data  = acc_rnd;
    case (state_r)
      ST_IDLE: begin
        if (up_i.valid) begin
          acc_nxt   = ACC_W'(up_i.data) <<< COEF_FRAC;
          state_nxt = ST_P1;
        end
      end
      ST_P1: begin
        acc_nxt   = acc_r - mul_ext;
        state_nxt = ST_P2;
      end
      ST_P2: begin
        acc_nxt   = acc_r - mul_ext;
        state_nxt = ST_W;
      end
      ST_W: begin
        w_nxt     = acc_rnd;
        acc_nxt   = ACC_W'(acc_rnd) <<< COEF_FRAC;
        state_nxt = ST_Z1;
      end
      ST_Z1: begin
        acc_nxt   = acc_r + mul_ext;
        state_nxt = ST_Z2;
      end
      ST_Z2: begin
        acc_nxt   = acc_r + mul_ext;
        h2_nxt    = h1_r;
        h1_nxt    = w_r;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (dn_ready_i) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control and history, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      h1_r    <= '0;
      h2_r    <= '0;
    end else begin
      state_r <= state_nxt;
      h1_r    <= h1_nxt;
      h2_r    <= h2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    w_r   <= w_nxt;
  end

`ifndef ASSERT_OFF
  a_hist_shift: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_Z2) |=> (h1_r == $past(w_r) && h2_r == $past(h1_r)))
    else $error("history not shifted at end of section");

  a_hist_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_Z2) |=> ($stable(h1_r) && $stable(h2_r)))
    else $error("history changed outside of update step");

  a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && !dn_ready_i) |=> (state_r == ST_DONE && $stable(acc_r)))
    else $error("section result lost while downstream stalled");
`endif

endmodule
